// File: src/vrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrr_pkg
// Shared constants and types of the varispeed ring resampler.
// ----------------------------------------------------------------------------
package vrr_pkg;

    localparam int RING_DEPTH_DEFAULT = 2048;

    localparam int FRAC_BITS = 14;
    localparam int SAMPLE_W  = 16;
    localparam int LAG_W     = 11;
    localparam int TSPEED_W  = 16;
    localparam int SPEED_W   = 24;
    localparam int STEP_W    = 19;
    localparam int SMOOTH_W  = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TSPEED_W-1:0] TSPEED_MIN   = 16'd8192;
    localparam logic [TSPEED_W-1:0] TSPEED_MAX   = 16'd40960;
    localparam logic [TSPEED_W-1:0] TSPEED_RESET = 16'd16384;
    localparam logic [SPEED_W-1:0]  SPEED_RESET  = 24'd4194304;
    localparam logic [SMOOTH_W-1:0] SMOOTH_K     = 11'd1311;
    localparam logic [LAG_W-1:0]    MIN_LAG_RESET = 11'd256;
    localparam logic [LAG_W-1:0]    MAX_LAG_RESET = 11'd1024;
    localparam int MAX_LAG_RESET_INT = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAG      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG      = 2'd2;

    typedef struct packed {
        logic capture;
        logic fwd0;
        logic fwd1;
        logic ok0;
        logic ok1;
    } rd_ctl_t;

endpackage

// File: src/varispeed_ring_resampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varispeed_ring_resampler_top
// Variable-speed resampler over a sample ring with linear interpolation.
// ----------------------------------------------------------------------------
// Input beats carry one signed sample in s_tdata and the block-start flag in
// s_tuser; each input beat yields exactly one output beat on m_tdata.
// A beat is taken when tvalid and tready are both high.
// The cycle after acceptance writes the sample into the ring and issues
// both interpolation reads on a pair of mirrored RAMs, so s_tready drops
// for that cycle and a new beat cannot enter while the write is under way.
// Results pass through the RAM read register and the capture register.
// Results wait in a two-entry output queue; while m_tready is low up to three
// beats are held in flight before s_tready drops, and nothing is lost.
// The configuration port writes target speed, min lag and max lag by index;
// write it only while the block is idle.
// Reset (aresetn low, synchronous) restores the control registers only. Ring
// entries unwritten since reset read as zero, tracked by write index and wrap
// flag, so no clearing pass is needed. RING_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module varispeed_ring_resampler_top #(
    parameter int RING_DEPTH = vrr_pkg::RING_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [vrr_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [vrr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [15:0] sample_in
    input  logic                                s_tuser,   // [0] block_start
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata    // [15:0] sample_out
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FB = vrr_pkg::FRAC_BITS;
    localparam int PW = AW + FB;
    localparam int LW = (AW > vrr_pkg::LAG_W) ? AW : vrr_pkg::LAG_W;
    localparam int RST_IDX =
        (RING_DEPTH - (vrr_pkg::MAX_LAG_RESET_INT % RING_DEPTH)) % RING_DEPTH;

    logic                                beat_in;
    logic                                pop;
    logic                                p1_reg;
    logic                                rd_reg;
    logic [1:0]                          cnt_reg;
    logic [1:0]                          cnt_next;
    logic signed [vrr_pkg::SAMPLE_W-1:0] sample_reg;
    logic [AW-1:0]                       wi_reg;
    logic [AW-1:0]                       wi_next;
    logic                                wrap_reg;
    logic                                wrap_next;
    logic [PW-1:0]                       pos_reg;
    logic [PW-1:0]                       pos_next;
    logic [vrr_pkg::LAG_W-1:0]           min_lag_reg;
    logic [vrr_pkg::LAG_W-1:0]           max_lag_reg;
    logic [LW-1:0]                       min_ext;
    logic [LW-1:0]                       max_ext;
    logic [AW-1:0]                       ri;
    logic [AW-1:0]                       lag;
    logic [LW-1:0]                       lag_ext;
    logic [AW-1:0]                       ri_new;
    logic [FB-1:0]                       frac_new;
    logic [AW-1:0]                       ri2;
    logic [vrr_pkg::TSPEED_W-1:0]        speed_step;
    logic [vrr_pkg::SAMPLE_W-1:0]        rdata0;
    logic [vrr_pkg::SAMPLE_W-1:0]        rdata1;
    logic                                fwd0_reg;
    logic                                fwd1_reg;
    logic                                ok0_reg;
    logic                                ok1_reg;
    vrr_pkg::rd_ctl_t                    rd_ctl;

    assign s_tready = !p1_reg && (cnt_reg != 2'd3);
    assign beat_in  = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        unique case ({beat_in, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    // lag check and jump for the current item
    assign wi_next   = wi_reg + AW'(1);
    assign wrap_next = wrap_reg || (wi_reg == AW'(RING_DEPTH - 1));
    assign min_ext   = LW'(min_lag_reg);
    assign max_ext   = LW'(max_lag_reg);
    assign ri        = pos_reg[PW-1:FB];
    assign lag       = wi_next - ri;
    assign lag_ext   = LW'(lag);

    always_comb begin
        priority if (lag_ext < min_ext) begin
            ri_new   = wi_next - max_ext[AW-1:0];
            frac_new = '0;
        end else if (lag_ext > max_ext) begin
            ri_new   = wi_next - min_ext[AW-1:0];
            frac_new = '0;
        end else begin
            ri_new   = ri;
            frac_new = pos_reg[FB-1:0];
        end
    end

    assign ri2 = ri_new + AW'(1);

    always_comb begin
        pos_next = pos_reg;
        if (p1_reg) begin
            pos_next = {ri_new, frac_new};
        end else if (rd_reg) begin
            pos_next = pos_reg + PW'(speed_step);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg      <= 1'b0;
            rd_reg      <= 1'b0;
            cnt_reg     <= 2'd0;
            wi_reg      <= '0;
            wrap_reg    <= 1'b0;
            pos_reg     <= {AW'(RST_IDX), {FB{1'b0}}};
            min_lag_reg <= vrr_pkg::MIN_LAG_RESET;
            max_lag_reg <= vrr_pkg::MAX_LAG_RESET;
        end else begin
            p1_reg  <= beat_in;
            rd_reg  <= p1_reg;
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
            if (p1_reg) begin
                wi_reg   <= wi_next;
                wrap_reg <= wrap_next;
            end
            if (cfg_we && cfg_addr == vrr_pkg::CFG_MIN_LAG) begin
                min_lag_reg <= cfg_wdata[vrr_pkg::LAG_W-1:0];
            end
            if (cfg_we && cfg_addr == vrr_pkg::CFG_MAX_LAG) begin
                max_lag_reg <= cfg_wdata[vrr_pkg::LAG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_in) begin
            sample_reg <= $signed(s_tdata);
        end
        if (p1_reg) begin
            fwd0_reg <= (ri_new == wi_reg);
            fwd1_reg <= (ri2 == wi_reg);
            ok0_reg  <= wrap_next || (ri_new < wi_next);
            ok1_reg  <= wrap_next || (ri2 < wi_next);
        end
    end

    assign rd_ctl.capture = rd_reg;
    assign rd_ctl.fwd0    = fwd0_reg;
    assign rd_ctl.fwd1    = fwd1_reg;
    assign rd_ctl.ok0     = ok0_reg;
    assign rd_ctl.ok1     = ok1_reg;

    vrr_ram #(
        .WIDTH (vrr_pkg::SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram0 (
        .aclk  (aclk),
        .we    (p1_reg),
        .waddr (wi_reg),
        .wdata (sample_reg),
        .raddr (ri_new),
        .rdata (rdata0)
    );

    vrr_ram #(
        .WIDTH (vrr_pkg::SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram1 (
        .aclk  (aclk),
        .we    (p1_reg),
        .waddr (wi_reg),
        .wdata (sample_reg),
        .raddr (ri2),
        .rdata (rdata1)
    );

    vrr_speed u_speed (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .beat_in     (beat_in),
        .block_start (s_tuser),
        .apply       (p1_reg),
        .speed_step  (speed_step)
    );

    vrr_interp u_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_ctl    (rd_ctl),
        .wr_sample (sample_reg),
        .rdata0    (rdata0),
        .rdata1    (rdata1),
        .frac      (pos_reg[FB-1:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: src/vrr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vrr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/vrr_speed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrr_speed
// Target speed register and first-order smoothing of the playback speed.
// ----------------------------------------------------------------------------
module vrr_speed (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [vrr_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [vrr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                beat_in,
    input  logic                                block_start,
    input  logic                                apply,
    output logic [vrr_pkg::TSPEED_W-1:0]        speed_step
);

    localparam int SW = vrr_pkg::SPEED_W;
    localparam int PW = vrr_pkg::SPEED_W + vrr_pkg::SMOOTH_W;

    logic [vrr_pkg::TSPEED_W-1:0] target_reg;
    logic [vrr_pkg::TSPEED_W-1:0] target_next;
    logic [SW-1:0]                speed_reg;
    logic [SW-1:0]                speed_next;
    logic [vrr_pkg::STEP_W-1:0]   step_reg;
    logic                         up_reg;
    logic                         bs_reg;
    logic [SW-1:0]                tgt_wide;
    logic                         up;
    logic [SW-1:0]                mag;
    logic [PW-1:0]                prod;

    always_comb begin
        priority if (cfg_wdata < vrr_pkg::TSPEED_MIN) begin
            target_next = vrr_pkg::TSPEED_MIN;
        end else if (cfg_wdata > vrr_pkg::TSPEED_MAX) begin
            target_next = vrr_pkg::TSPEED_MAX;
        end else begin
            target_next = cfg_wdata;
        end
    end

    assign tgt_wide = {target_reg, 8'd0};
    assign up       = (tgt_wide >= speed_reg);
    assign mag      = up ? (tgt_wide - speed_reg) : (speed_reg - tgt_wide);
    assign prod     = PW'(mag) * PW'(vrr_pkg::SMOOTH_K);

    always_comb begin
        speed_next = speed_reg;
        if (apply && bs_reg) begin
            if (up_reg) begin
                speed_next = speed_reg + SW'(step_reg);
            end else begin
                speed_next = speed_reg - SW'(step_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= vrr_pkg::TSPEED_RESET;
            speed_reg  <= vrr_pkg::SPEED_RESET;
            bs_reg     <= 1'b0;
        end else begin
            if (cfg_we && cfg_addr == vrr_pkg::CFG_TARGET_SPEED) begin
                target_reg <= target_next;
            end
            speed_reg <= speed_next;
            if (beat_in) begin
                bs_reg <= block_start;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_in) begin
            step_reg <= prod[16 +: vrr_pkg::STEP_W];
            up_reg   <= up;
        end
    end

    assign speed_step = speed_reg[SW-1:8];

endmodule

// File: src/vrr_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrr_interp
// Linear interpolation of the two ring samples and a two-entry output queue.
// ----------------------------------------------------------------------------
module vrr_interp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  vrr_pkg::rd_ctl_t                    rd_ctl,
    input  logic signed [vrr_pkg::SAMPLE_W-1:0] wr_sample,
    input  logic [vrr_pkg::SAMPLE_W-1:0]        rdata0,
    input  logic [vrr_pkg::SAMPLE_W-1:0]        rdata1,
    input  logic [vrr_pkg::FRAC_BITS-1:0]       frac,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [vrr_pkg::SAMPLE_W-1:0]        m_tdata
);

    localparam int DW = vrr_pkg::SAMPLE_W + 1;
    localparam int MW = DW + vrr_pkg::FRAC_BITS;
    localparam int NW = MW + 1;

    logic signed [vrr_pkg::SAMPLE_W-1:0] s0;
    logic signed [vrr_pkg::SAMPLE_W-1:0] s1;
    logic signed [DW-1:0]                diff;
    logic signed [MW:0]                  prod_full;
    logic                                c_v_reg;
    logic                                c_v_next;
    logic signed [vrr_pkg::SAMPLE_W-1:0] c_s0_reg;
    logic signed [MW-1:0]                c_prod_reg;
    logic signed [NW-1:0]                num;
    logic signed [NW-1:0]                num_adj;
    logic signed [NW-1:0]                num_shr;
    logic [vrr_pkg::SAMPLE_W-1:0]        y;
    logic [vrr_pkg::SAMPLE_W-1:0]        q0_reg;
    logic [vrr_pkg::SAMPLE_W-1:0]        q1_reg;
    logic [1:0]                          qcnt_reg;
    logic                                push;
    logic                                pop;

    always_comb begin
        priority if (rd_ctl.fwd0) begin
            s0 = wr_sample;
        end else if (rd_ctl.ok0) begin
            s0 = $signed(rdata0);
        end else begin
            s0 = '0;
        end
        priority if (rd_ctl.fwd1) begin
            s1 = wr_sample;
        end else if (rd_ctl.ok1) begin
            s1 = $signed(rdata1);
        end else begin
            s1 = '0;
        end
    end

    assign diff      = DW'(s1) - DW'(s0);
    assign prod_full = (MW + 1)'(diff) * (MW + 1)'($signed({1'b0, frac}));

    assign num     = (NW'(c_s0_reg) <<< vrr_pkg::FRAC_BITS) + NW'(c_prod_reg);
    assign num_adj = num[NW-1] ? (num + NW'((1 << vrr_pkg::FRAC_BITS) - 1)) : num;
    assign num_shr = num_adj >>> vrr_pkg::FRAC_BITS;
    assign y       = num_shr[vrr_pkg::SAMPLE_W-1:0];

    assign pop  = m_tvalid && m_tready;
    assign push = c_v_reg && (qcnt_reg != 2'd2);

    always_comb begin
        c_v_next = c_v_reg;
        if (rd_ctl.capture) begin
            c_v_next = 1'b1;
        end else if (push) begin
            c_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_ctl.capture) begin
            c_s0_reg   <= s0;
            c_prod_reg <= prod_full[MW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg  <= 1'b0;
            qcnt_reg <= 2'd0;
        end else begin
            c_v_reg <= c_v_next;
            unique case ({push, pop})
                2'b10: begin
                    qcnt_reg <= qcnt_reg + 2'd1;
                end
                2'b01: begin
                    qcnt_reg <= qcnt_reg - 2'd1;
                end
                default: begin
                    qcnt_reg <= qcnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case ({push, pop})
            2'b10: begin
                if (qcnt_reg == 2'd0) begin
                    q0_reg <= y;
                end else begin
                    q1_reg <= y;
                end
            end
            2'b01: begin
                q0_reg <= q1_reg;
            end
            2'b11: begin
                if (qcnt_reg == 2'd1) begin
                    q0_reg <= y;
                end else begin
                    q0_reg <= q1_reg;
                    q1_reg <= y;
                end
            end
            default: begin
                q0_reg <= q0_reg;
            end
        endcase
    end

    assign m_tvalid = (qcnt_reg != 2'd0);
    assign m_tdata  = q0_reg;

endmodule
